@@ design/grid_quadrature_accumulator_defines.svh @@
// Assertion macros used by the checker file of the quadrature accumulator.
// Assumes clk and rst_n are visible where a macro is used.
`ifndef GRID_QUADRATURE_ACCUMULATOR_DEFINES_SVH
`define GRID_QUADRATURE_ACCUMULATOR_DEFINES_SVH

// consequent in the cycle after the antecedent
`define GQA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quadrature accumulator assertion failed");

// consequent in the same cycle as the antecedent
`define GQA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quadrature accumulator assertion failed");

`endif

@@ design/gqa_pkg.sv @@
// Types, widths and codes of the grid quadrature accumulator.
// No dependencies; every other design file but the defines header imports it.
package gqa_pkg;

  localparam int SMP_W      = 32;
  localparam int ACC_W      = 64;
  localparam int STEP_W     = 31;
  localparam int H_W        = 33;
  localparam int SUM_W      = 34;
  localparam int MOP_W      = 36;
  localparam int WIDE_W     = 136;
  localparam int DEN_W      = 68;
  localparam int DCNT_W     = 8;
  localparam int MCNT_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int STAT_W     = 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_METHOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

  typedef enum logic [1:0] {
    METHOD_LEFT,
    METHOD_RIGHT,
    METHOD_TRAP,
    METHOD_SIMPSON
  } method_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK,
    STATUS_TOO_FEW,
    STATUS_ODD,
    STATUS_SAT
  } status_t;

  typedef enum logic [2:0] {
    MOP_T0,
    MOP_A,
    MOP_SS,
    MOP_B,
    MOP_T2,
    MOP_C,
    MOP_NUM,
    MOP_DEN
  } mul_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_PROD_PREV,
    S_PROD_CUR,
    S_TERM,
    S_ACC,
    S_MUL_START,
    S_MUL_WAIT,
    S_DEN_CHK,
    S_DIV_WAIT,
    S_QUOT,
    S_ADVANCE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    diff;
    logic    prod_prev;
    logic    prod_cur;
    logic    term;
    logic    acc_add;
    logic    mul_start;
    mul_op_t mul_op;
    logic    div_start;
    logic    quot_add;
    logic    advance;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    method_t method;
    logic    count_zero;
    logic    count_even;
    logic    mul_done;
    logic    div_done;
    logic    den_zero;
    logic    close;
  } dp_status_t;

endpackage

@@ design/gqa_in_if.sv @@
// Sample request channel: valid, ready and one grid sample.
// Depends on gqa_pkg.
interface gqa_in_if;
  import gqa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SMP_W-1:0]  sample_x;
  logic signed [SMP_W-1:0]  sample_y;
  logic                     last_sample;

  modport source (output valid, output sample_x, output sample_y, output last_sample,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input last_sample,
                output ready);
endinterface

@@ design/gqa_out_if.sv @@
// Result request channel: valid, ready, integral and status.
// Depends on gqa_pkg.
interface gqa_out_if;
  import gqa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ACC_W-1:0]  integral_value;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output integral_value, output status, input ready);
  modport sink (input valid, input integral_value, input status, output ready);
endinterface

@@ design/gqa_div.sv @@
// Restoring divider, one quotient bit per cycle, for the Simpson panel quotient.
// Depends on gqa_pkg.
module gqa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gqa_pkg::WIDE_W-1:0]  num_mag,
  input  logic [gqa_pkg::DEN_W-1:0]   den_mag,
  output logic                        done,
  output logic [gqa_pkg::ACC_W-1:0]   quot,
  output logic                        big
);
  import gqa_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [DCNT_W-1:0]   cnt_r;
  logic [WIDE_W-1:0]   nsh_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem_r;
  logic [ACC_W-1:0]    q_r;
  logic                big_r;

  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_diff;
  logic                ge;
  logic [DEN_W-1:0]    rem_nxt;
  logic                last;

  assign rem_sh   = {rem_r, nsh_r[WIDE_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign ge       = rem_sh >= {1'b0, den_r};
  assign rem_nxt  = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign last     = cnt_r == DCNT_W'(WIDE_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh_r <= num_mag;
      den_r <= den_mag;
      rem_r <= '0;
      q_r   <= '0;
      big_r <= 1'b0;
    end else if (busy_r) begin
      nsh_r <= {nsh_r[WIDE_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[ACC_W-2:0], ge};
      big_r <= big_r | q_r[ACC_W-1];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign big  = big_r;
endmodule

@@ design/gqa_datapath.sv @@
// Datapath: configuration, sample history, rule terms, serial multiplier,
// saturating accumulator and result register. Depends on gqa_pkg and gqa_div.
module gqa_datapath #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gqa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gqa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic signed [gqa_pkg::SMP_W-1:0] in_sample_x,
  input  logic signed [gqa_pkg::SMP_W-1:0] in_sample_y,
  input  logic                             in_last_sample,
  input  gqa_pkg::dp_cmd_t                 cmd,
  output gqa_pkg::dp_status_t              status,
  output logic signed [gqa_pkg::ACC_W-1:0] res_value,
  output logic [gqa_pkg::STAT_W-1:0]       res_status
);
  import gqa_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                             input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      return {1'b1, (a[ACC_W-1] ? ACC_MIN : ACC_MAX)};
    end
    return {1'b0, s};
  endfunction

  method_t                   method_r;
  logic                      uniform_r;
  logic [STEP_W-1:0]         step_r;

  logic signed [SMP_W-1:0]   x_r, y_r;
  logic                      last_r;
  logic signed [SMP_W-1:0]   prev_x_r, prev_y_r, old_x_r, old_y_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_inc;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      sat_r, sat_nxt;

  logic signed [H_W-1:0]     dx_r, h0_r, dx_calc, h0_calc;
  logic signed [ACC_W-1:0]   p0_r, p1_r, term_r, term_calc;
  logic signed [SMP_W-1:0]   prod_y;
  logic signed [H_W+SMP_W-1:0] prod_full;
  logic signed [ACC_W:0]     trap_sum;

  logic signed [SUM_W-1:0]   s_sum;
  logic signed [H_W+1:0]     two_h0_m_h1, two_h1_m_h0;
  logic signed [MOP_W-1:0]   h0_x, six_h0;
  logic signed [WIDE_W-1:0]  mw_r, mw_load;
  logic signed [MOP_W-1:0]   mm_r, mm_load;
  logic signed [WIDE_W-1:0]  mp_r, mp_nxt, mul_add;
  logic [MCNT_W-1:0]         mcnt_r;
  logic                      mbusy_r, mdone_r, mul_last;
  mul_op_t                   mop_r;
  logic signed [WIDE_W-1:0]  t_r, n_r;
  logic signed [DEN_W-1:0]   d_r;

  logic [WIDE_W-1:0]         num_mag;
  logic [DEN_W-1:0]          den_mag;
  logic                      neg_r;
  logic                      div_done, div_big;
  logic [ACC_W-1:0]          div_q;
  logic                      quot_over;
  logic signed [ACC_W-1:0]   q_signed, add_in;
  logic [ACC_W:0]            add_res;

  logic signed [ACC_W-1:0]   res_value_r;
  status_t                   res_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r  <= METHOD_TRAP;
      uniform_r <= 1'b0;
      step_r    <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_METHOD:  method_r  <= method_t'(cfg_wdata[1:0]);
        CFG_UNIFORM: uniform_r <= cfg_wdata[0];
        CFG_STEP:    step_r    <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r    <= in_sample_x;
      y_r    <= in_sample_y;
      last_r <= in_last_sample;
    end
  end

  assign dx_calc = uniform_r ? {{(H_W-STEP_W){1'b0}}, step_r}
                             : {x_r[SMP_W-1], x_r} - {prev_x_r[SMP_W-1], prev_x_r};
  assign h0_calc = uniform_r ? {{(H_W-STEP_W){1'b0}}, step_r}
                             : {prev_x_r[SMP_W-1], prev_x_r} - {old_x_r[SMP_W-1], old_x_r};

  assign prod_y    = cmd.prod_prev ? prev_y_r : y_r;
  assign prod_full = dx_r * prod_y;
  assign trap_sum  = {p0_r[ACC_W-1], p0_r} + {p1_r[ACC_W-1], p1_r};

  always_comb begin
    case (method_r)
      METHOD_LEFT:  term_calc = p0_r;
      METHOD_RIGHT: term_calc = p1_r;
      default:      term_calc = trap_sum[ACC_W:1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx_r <= dx_calc;
      h0_r <= h0_calc;
    end
    if (cmd.prod_prev) p0_r <= prod_full[ACC_W-1:0];
    if (cmd.prod_cur) p1_r <= prod_full[ACC_W-1:0];
    if (cmd.term) term_r <= term_calc;
  end

  assign s_sum       = {h0_r[H_W-1], h0_r} + {dx_r[H_W-1], dx_r};
  assign two_h0_m_h1 = {h0_r[H_W-1], h0_r, 1'b0} - {{2{dx_r[H_W-1]}}, dx_r};
  assign two_h1_m_h0 = {dx_r[H_W-1], dx_r, 1'b0} - {{2{h0_r[H_W-1]}}, h0_r};
  assign h0_x        = MOP_W'(h0_r);
  assign six_h0      = (h0_x <<< 2) + (h0_x <<< 1);

  always_comb begin
    case (cmd.mul_op)
      MOP_T0: begin
        mw_load = WIDE_W'(two_h0_m_h1);
        mm_load = MOP_W'(dx_r);
      end
      MOP_A: begin
        mw_load = t_r;
        mm_load = MOP_W'(old_y_r);
      end
      MOP_SS: begin
        mw_load = WIDE_W'(s_sum);
        mm_load = MOP_W'(s_sum);
      end
      MOP_B: begin
        mw_load = t_r;
        mm_load = MOP_W'(prev_y_r);
      end
      MOP_T2: begin
        mw_load = WIDE_W'(two_h1_m_h0);
        mm_load = MOP_W'(h0_r);
      end
      MOP_C: begin
        mw_load = t_r;
        mm_load = MOP_W'(y_r);
      end
      MOP_NUM: begin
        mw_load = n_r;
        mm_load = MOP_W'(s_sum);
      end
      default: begin
        mw_load = WIDE_W'(six_h0);
        mm_load = MOP_W'(dx_r);
      end
    endcase
  end

  assign mul_add  = mm_r[MOP_W-1] ? ((mcnt_r == '0) ? -mw_r : mw_r) : '0;
  assign mp_nxt   = (mp_r <<< 1) + mul_add;
  assign mul_last = mcnt_r == MCNT_W'(MOP_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
      mcnt_r  <= '0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.mul_start) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= '0;
      end else if (mbusy_r && mul_last) begin
        mbusy_r <= 1'b0;
        mdone_r <= 1'b1;
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mw_r  <= mw_load;
      mm_r  <= mm_load;
      mp_r  <= '0;
      mop_r <= cmd.mul_op;
    end else if (mbusy_r) begin
      mp_r <= mp_nxt;
      mm_r <= mm_r <<< 1;
      if (mul_last) begin
        case (mop_r) inside
          MOP_T0, MOP_SS, MOP_T2: t_r <= mp_nxt;
          MOP_A, MOP_NUM:         n_r <= mp_nxt;
          MOP_B, MOP_C:           n_r <= n_r + mp_nxt;
          default:                d_r <= mp_nxt[DEN_W-1:0];
        endcase
      end
    end
  end

  assign num_mag = n_r[WIDE_W-1] ? -n_r : n_r;
  assign den_mag = d_r[DEN_W-1] ? -d_r : d_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) neg_r <= n_r[WIDE_W-1] ^ d_r[DEN_W-1];
  end

  gqa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num_mag (num_mag),
    .den_mag (den_mag),
    .done    (div_done),
    .quot    (div_q),
    .big     (div_big)
  );

  assign quot_over = div_big || (neg_r ? (div_q > {1'b1, {(ACC_W-1){1'b0}}})
                                       : div_q[ACC_W-1]);
  assign q_signed  = neg_r ? -div_q : div_q;
  assign add_in    = cmd.quot_add ? q_signed : term_r;
  assign add_res   = sat_add(acc_r, add_in);

  always_comb begin
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    if (cmd.emit) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
    end else if (cmd.quot_add && quot_over) begin
      acc_nxt = neg_r ? ACC_MIN : ACC_MAX;
      sat_nxt = 1'b1;
    end else if (cmd.acc_add || cmd.quot_add) begin
      acc_nxt = add_res[ACC_W-1:0];
      sat_nxt = sat_r | add_res[ACC_W];
    end
  end

  assign count_inc = count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      sat_r    <= 1'b0;
      count_r  <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      old_x_r  <= '0;
      old_y_r  <= '0;
    end else begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
      if (cmd.emit) begin
        count_r  <= '0;
        prev_x_r <= '0;
        prev_y_r <= '0;
        old_x_r  <= '0;
        old_y_r  <= '0;
      end else if (cmd.advance) begin
        count_r  <= count_inc;
        old_x_r  <= prev_x_r;
        old_y_r  <= prev_y_r;
        prev_x_r <= x_r;
        prev_y_r <= y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (count_r < CNT_W'(2)) begin
        res_value_r  <= '0;
        res_status_r <= STATUS_TOO_FEW;
      end else if (method_r == METHOD_SIMPSON && !count_r[0]) begin
        res_value_r  <= '0;
        res_status_r <= STATUS_ODD;
      end else begin
        res_value_r  <= acc_r;
        res_status_r <= sat_r ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  assign res_value  = res_value_r;
  assign res_status = res_status_r;

  assign status.method     = method_r;
  assign status.count_zero = count_r == '0;
  assign status.count_even = !count_r[0];
  assign status.mul_done   = mdone_r;
  assign status.div_done   = div_done;
  assign status.den_zero   = d_r == '0;
  assign status.close      = last_r || (count_inc == CNT_W'(MAX_POINTS));
endmodule

@@ design/gqa_ctrl.sv @@
// Controller: sequences each sample request through the datapath and owns
// the request handshakes. Depends on gqa_pkg.
module gqa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output gqa_pkg::dp_cmd_t    cmd,
  input  gqa_pkg::dp_status_t status
);
  import gqa_pkg::*;

  state_t  state_r, state_nxt;
  mul_op_t op_r, op_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    emit_go;

  assign emit_go = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_DIFF;
      S_DIFF: begin
        if (status.count_zero) begin
          state_nxt = S_ADVANCE;
        end else if (status.method != METHOD_SIMPSON) begin
          state_nxt = S_PROD_PREV;
        end else if (status.count_even) begin
          state_nxt = S_MUL_START;
          op_nxt    = MOP_T0;
        end else begin
          state_nxt = S_ADVANCE;
        end
      end
      S_PROD_PREV: state_nxt = S_PROD_CUR;
      S_PROD_CUR:  state_nxt = S_TERM;
      S_TERM:      state_nxt = S_ACC;
      S_ACC:       state_nxt = S_ADVANCE;
      S_MUL_START: state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (status.mul_done) begin
          if (op_r == MOP_DEN) begin
            state_nxt = S_DEN_CHK;
          end else begin
            state_nxt = S_MUL_START;
            op_nxt    = mul_op_t'(op_r + 1'b1);
          end
        end
      end
      S_DEN_CHK:   state_nxt = status.den_zero ? S_ADVANCE : S_DIV_WAIT;
      S_DIV_WAIT:  if (status.div_done) state_nxt = S_QUOT;
      S_QUOT:      state_nxt = S_ADVANCE;
      S_ADVANCE:   state_nxt = status.close ? S_EMIT : S_IDLE;
      S_EMIT:      if (emit_go) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_op    = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE:      cmd.capture = in_valid;
      S_DIFF:      cmd.diff = 1'b1;
      S_PROD_PREV: cmd.prod_prev = 1'b1;
      S_PROD_CUR:  cmd.prod_cur = 1'b1;
      S_TERM:      cmd.term = 1'b1;
      S_ACC:       cmd.acc_add = 1'b1;
      S_MUL_START: cmd.mul_start = 1'b1;
      S_DEN_CHK:   cmd.div_start = !status.den_zero;
      S_QUOT:      cmd.quot_add = 1'b1;
      S_ADVANCE:   cmd.advance = 1'b1;
      S_EMIT: begin
        cmd.emit = emit_go;
        if (emit_go) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= MOP_T0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
endmodule

@@ design/grid_quadrature_accumulator.sv @@
// Grid quadrature accumulator: integrates a stream of (x, y, last) samples by
// left rectangle, right rectangle, trapezoid or Simpson rule and returns one
// Q32.32 integral with a status when the integral closes. Under the rectangle
// and trapezoid rules a sample after the first passes difference, two products,
// term, accumulate and advance; the odd samples under Simpson pass difference
// and advance, and a sample that closes a Simpson panel runs the bit-serial
// 136x36 multiplier in eight passes and then the one-bit-per-cycle restoring
// divider. The result waits in an output register while the next sample is
// taken, and a second close stalls until that result is taken.
module grid_quadrature_accumulator #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gqa_in_if.sink                          in_chan,
  gqa_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [gqa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gqa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gqa_pkg::*;

  dp_cmd_t                 cmd;
  dp_status_t              dp_status;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [ACC_W-1:0] res_value;
  logic [STAT_W-1:0]       res_status;

  gqa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .status    (dp_status)
  );

  gqa_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_sample_x    (in_chan.sample_x),
    .in_sample_y    (in_chan.sample_y),
    .in_last_sample (in_chan.last_sample),
    .cmd            (cmd),
    .status         (dp_status),
    .res_value      (res_value),
    .res_status     (res_status)
  );

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid;
  assign out_chan.integral_value = res_value;
  assign out_chan.status         = res_status;
endmodule

@@ design/gqa_checker.sv @@
// Port-level checks of the grid quadrature accumulator, bound to the top level.
// Depends on gqa_pkg and grid_quadrature_accumulator_defines.svh.
`include "grid_quadrature_accumulator_defines.svh"

module gqa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [gqa_pkg::ACC_W-1:0] out_integral_value,
  input logic [gqa_pkg::STAT_W-1:0]      out_status
);
  import gqa_pkg::*;

  `GQA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `GQA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_integral_value) && $stable(out_status))
  `GQA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `GQA_ASSERT_NOW(a_err_zero, out_valid && (out_status == STATUS_TOO_FEW || out_status == STATUS_ODD), out_integral_value == '0)
endmodule

bind grid_quadrature_accumulator gqa_checker u_gqa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_integral_value (out_chan.integral_value),
  .out_status         (out_chan.status)
);
